@@ sv/vtf_pkg.sv @@
// Shared types, codes and constant functions for the volume transfer function block.
// Used by every module of the block; depends on nothing.
package vtf_pkg;

  localparam int NUM_FUNCS_DEF   = 8;
  localparam int NUM_VALUES_DEF  = 5;
  localparam int EXP_DEPTH_DEF   = 256;

  localparam int VALUE_W       = 32;
  localparam int COLOR_W       = 48;
  localparam int CHAN_W        = 16;
  localparam int KIND_W        = 2;
  localparam int VSEL_W        = 3;
  localparam int SLOT_W        = 3;
  localparam int ACT_W         = 4;
  localparam int EXP_W         = 17;
  localparam int SAMPLE_FIELDS = 5;
  localparam int LANE_STAGES   = 7;
  localparam int CONTRIB_W     = 42;
  localparam int SUM_W         = 48;

  localparam logic ITEM_LOAD   = 1'b0;
  localparam logic ITEM_SAMPLE = 1'b1;

  localparam logic [KIND_W-1:0] FT_DISABLED = 2'd0;
  localparam logic [KIND_W-1:0] FT_CONST    = 2'd1;
  localparam logic [KIND_W-1:0] FT_TOPHAT   = 2'd2;
  localparam logic [KIND_W-1:0] FT_GAUSS    = 2'd3;

  localparam logic [VSEL_W-1:0] VS_DENSITY = 3'd0;
  localparam logic [VSEL_W-1:0] VS_THERMAL = 3'd1;
  localparam logic [VSEL_W-1:0] VS_VEL_X   = 3'd2;
  localparam logic [VSEL_W-1:0] VS_VEL_Y   = 3'd3;
  localparam logic [VSEL_W-1:0] VS_VEL_Z   = 3'd4;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [VSEL_W-1:0]         vidx;
    logic signed [VALUE_W-1:0] low;
    logic signed [VALUE_W-1:0] high;
    logic signed [VALUE_W-1:0] mean;
    logic [VALUE_W-1:0]        scale;
    logic [COLOR_W-1:0]        color;
  } entry_t;

  typedef logic signed [CONTRIB_W-1:0] contrib_t;

  function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = SUM_W'(64'sh7FFF_FFFF);
    lo_lim = -SUM_W'(64'sh8000_0000);
    if (x > hi_lim) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo_lim) begin
      return 32'sh8000_0000;
    end
    return x[VALUE_W-1:0];
  endfunction

  // Series for exp(-f) in Q2.30, f in Q2.30, terms up to f^24.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = Q30_ONE;
    pos  = Q30_ONE;
    neg  = '0;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * f) >> 30) / 64'(i);
      if ((i % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return pos - neg;
  endfunction

  function automatic logic [63:0] exp_pow_e1(input logic [63:0] v, input logic [63:0] n);
    logic [63:0] e1;
    logic [63:0] acc;
    e1  = exp_neg_q30(Q30_ONE);
    acc = v;
    for (int j = 0; j < 8; j++) begin
      if (64'(j) < n) begin
        acc = (acc * e1) >> 30;
      end
    end
    return acc;
  endfunction

endpackage

@@ sv/vtf_load.sv @@
// Slot table and load sequencer: squares sigma, runs a radix-2 divider for 1/(2 sigma^2)
// and writes a slot once the sample pipeline is empty. Depends on vtf_pkg.
module vtf_load import vtf_pkg::*; #(
  parameter int NUM_FUNCS  = NUM_FUNCS_DEF,
  parameter int NUM_VALUES = NUM_VALUES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ld_start,
  input  logic [SLOT_W-1:0]         ld_slot,
  input  logic [KIND_W-1:0]         ld_type,
  input  logic [VSEL_W-1:0]         ld_vsel,
  input  logic signed [VALUE_W-1:0] ld_a,
  input  logic signed [VALUE_W-1:0] ld_b,
  input  logic [COLOR_W-1:0]        ld_color,
  input  logic                      pipe_empty,
  output logic                      ld_idle,
  output entry_t                    ent [NUM_FUNCS]
);

  localparam logic [2:0] LD_IDLE = 3'd0;
  localparam logic [2:0] LD_SQR  = 3'd1;
  localparam logic [2:0] LD_NUMR = 3'd2;
  localparam logic [2:0] LD_DIV  = 3'd3;
  localparam logic [2:0] LD_WAIT = 3'd4;

  localparam int QUO_W = 48;
  localparam int DEN_W = 63;
  localparam int SH_W  = DEN_W + QUO_W - 1;

  logic [2:0]                st_r, st_nxt;
  logic [SLOT_W-1:0]         slot_r;
  logic [KIND_W-1:0]         type_r;
  logic [VSEL_W-1:0]         vsel_r;
  logic signed [VALUE_W-1:0] a_r;
  logic signed [VALUE_W-1:0] b_r;
  logic [COLOR_W-1:0]        color_r;
  logic [VALUE_W-1:0]        mag_r;
  logic [DEN_W-1:0]          den_r;
  logic [DEN_W-1:0]          rem_r;
  logic [SH_W-1:0]           den_sh_r;
  logic [QUO_W-1:0]          quo_r;
  logic [5:0]                cnt_r;
  logic                      fits;
  logic                      commit;
  entry_t                    wr;

  logic [KIND_W-1:0]         kind_r  [NUM_FUNCS];
  logic [VSEL_W-1:0]         vidx_r  [NUM_FUNCS];
  logic signed [VALUE_W-1:0] low_r   [NUM_FUNCS];
  logic signed [VALUE_W-1:0] high_r  [NUM_FUNCS];
  logic signed [VALUE_W-1:0] mean_r  [NUM_FUNCS];
  logic [VALUE_W-1:0]        scale_r [NUM_FUNCS];
  logic [COLOR_W-1:0]        col_r   [NUM_FUNCS];

  assign fits    = {{(SH_W-DEN_W){1'b0}}, rem_r} >= den_sh_r;
  assign commit  = (st_r == LD_WAIT) && pipe_empty;
  assign ld_idle = (st_r == LD_IDLE);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      LD_IDLE: begin
        if (ld_start) begin
          st_nxt = (ld_type == FT_GAUSS) ? LD_SQR : LD_WAIT;
        end
      end
      LD_SQR:  st_nxt = LD_NUMR;
      LD_NUMR: st_nxt = LD_DIV;
      LD_DIV: begin
        if (cnt_r == 6'd0) begin
          st_nxt = LD_WAIT;
        end
      end
      LD_WAIT: begin
        if (pipe_empty) begin
          st_nxt = LD_IDLE;
        end
      end
      default: st_nxt = LD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LD_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_idle && ld_start) begin
      slot_r  <= ld_slot;
      type_r  <= ld_type;
      vsel_r  <= ld_vsel;
      a_r     <= ld_a;
      b_r     <= ld_b;
      color_r <= ld_color;
      mag_r   <= ld_b[VALUE_W-1] ? VALUE_W'(-ld_b) : VALUE_W'(ld_b);
    end
    if (st_r == LD_SQR) begin
      den_r <= DEN_W'({32'd0, mag_r} * {32'd0, mag_r});
    end
    if (st_r == LD_NUMR) begin
      rem_r    <= (DEN_W'(1) << 47) + (den_r >> 1);
      den_sh_r <= {den_r, {(QUO_W-1){1'b0}}};
      quo_r    <= '0;
      cnt_r    <= 6'(QUO_W - 1);
    end
    if (st_r == LD_DIV) begin
      if (fits) begin
        rem_r <= rem_r - den_sh_r[DEN_W-1:0];
      end
      quo_r    <= {quo_r[QUO_W-2:0], fits};
      den_sh_r <= den_sh_r >> 1;
      cnt_r    <= cnt_r - 6'd1;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] a_x;
    logic signed [SUM_W-1:0] b4;
    a_x      = SUM_W'(a_r);
    b4       = SUM_W'(b_r) <<< 2;
    wr.kind  = (32'(vsel_r) < NUM_VALUES) ? type_r : FT_DISABLED;
    wr.vidx  = vsel_r;
    wr.mean  = a_r;
    wr.color = color_r;
    wr.scale = '0;
    unique case (wr.kind)
      FT_CONST: begin
        wr.low  = '0;
        wr.high = 32'sh7FFF_FFFF;
      end
      FT_TOPHAT: begin
        wr.low  = a_r;
        wr.high = b_r;
      end
      FT_GAUSS: begin
        wr.low  = sat32(a_x - b4);
        wr.high = sat32(a_x + b4);
        if (den_r == '0 || (|quo_r[QUO_W-1:VALUE_W])) begin
          wr.scale = '1;
        end else begin
          wr.scale = quo_r[VALUE_W-1:0];
        end
      end
      default: begin
        wr.low  = '0;
        wr.high = '0;
      end
    endcase
  end

  for (genvar i = 0; i < NUM_FUNCS; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        kind_r[i] <= FT_DISABLED;
        vidx_r[i] <= '0;
      end else if (commit && (32'(slot_r) == i)) begin
        kind_r[i] <= wr.kind;
        vidx_r[i] <= wr.vidx;
      end
    end

    always_ff @(posedge clk) begin
      if (commit && (32'(slot_r) == i)) begin
        low_r[i]   <= wr.low;
        high_r[i]  <= wr.high;
        mean_r[i]  <= wr.mean;
        scale_r[i] <= wr.scale;
        col_r[i]   <= wr.color;
      end
    end

    always_comb begin
      ent[i].kind  = kind_r[i];
      ent[i].vidx  = vidx_r[i];
      ent[i].low   = low_r[i];
      ent[i].high  = high_r[i];
      ent[i].mean  = mean_r[i];
      ent[i].scale = scale_r[i];
      ent[i].color = col_r[i];
    end
  end

endmodule

@@ sv/vtf_lane.sv @@
// One slot's evaluation pipeline: window test, squared distance, table index,
// exponential lookup and colour products. Depends on vtf_pkg.
module vtf_lane import vtf_pkg::*; #(
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      active,
  input  entry_t                    ent,
  input  logic signed [VALUE_W-1:0] smp [SAMPLE_FIELDS],
  output contrib_t                  contrib [3]
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

  logic [EXP_W-1:0] rom [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] X = 64'(8 * k);
    localparam logic [63:0] N = X / EXP_TABLE_DEPTH;
    localparam logic [63:0] R = X % EXP_TABLE_DEPTH;
    localparam logic [63:0] F = (R << 30) / EXP_TABLE_DEPTH;
    localparam logic [63:0] V = exp_pow_e1(exp_neg_q30(F), N);
    assign rom[k] = EXP_W'((V + 64'd8192) >> 14);
  end

  logic signed [VALUE_W-1:0] v;
  logic signed [VALUE_W:0]   d;
  logic                      hit;

  logic signed [VALUE_W-1:0] v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic                      h1_r, h2_r, h3_r, h4_r, h5_r, h6_r;
  logic [VALUE_W-1:0]        ud1_r;
  logic [63:0]               d2_r;
  logic [63:0]               ph_r, pl_r;
  logic [95:0]               t;
  logic                      big_r;
  logic [50:0]               t4_r;
  logic [63:0]               scaled;
  logic [IDX_W-1:0]          idx_r;
  logic [EXP_W-1:0]          w_r;
  contrib_t                  c_r [3];

  always_comb begin
    unique case (ent.vidx)
      VS_DENSITY: v = smp[0];
      VS_THERMAL: v = smp[1];
      VS_VEL_X:   v = smp[2];
      VS_VEL_Y:   v = smp[3];
      VS_VEL_Z:   v = smp[4];
      default:    v = '0;
    endcase
    d   = (VALUE_W+1)'(v) - (VALUE_W+1)'(ent.mean);
    hit = active && (ent.kind != FT_DISABLED) && (v >= ent.low) && (v <= ent.high);
  end

  assign t      = {ph_r, 32'd0} + {32'd0, pl_r};
  assign scaled = {13'd0, t4_r} * 64'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r  <= v;
      h1_r  <= hit;
      ud1_r <= d[VALUE_W] ? VALUE_W'(-d) : VALUE_W'(d);

      v2_r <= v1_r;
      h2_r <= h1_r;
      d2_r <= {32'd0, ud1_r} * {32'd0, ud1_r};

      v3_r <= v2_r;
      h3_r <= h2_r;
      ph_r <= {32'd0, d2_r[63:32]} * {32'd0, ent.scale};
      pl_r <= {32'd0, d2_r[31:0]} * {32'd0, ent.scale};

      v4_r  <= v3_r;
      h4_r  <= h3_r;
      big_r <= |t[95:51];
      t4_r  <= t[50:0];

      v5_r  <= v4_r;
      h5_r  <= h4_r;
      idx_r <= big_r ? IDX_W'(EXP_TABLE_DEPTH - 1) : scaled[51 +: IDX_W];

      v6_r <= v5_r;
      h6_r <= h5_r;
      w_r  <= rom[idx_r];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [CHAN_W-1:0]         col;
    logic [32:0]               g;
    logic signed [48:0]        m;
    assign col = ent.color[COLOR_W-1-CHAN_W*c -: CHAN_W];
    assign g   = {16'd0, col} * {16'd0, w_r};
    assign m   = $signed({1'b0, col}) * v6_r;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!h6_r) begin
          c_r[c] <= '0;
        end else if (ent.kind == FT_GAUSS) begin
          c_r[c] <= CONTRIB_W'({1'b0, g[32:8]});
        end else begin
          c_r[c] <= CONTRIB_W'($signed(m[48:8]));
        end
      end
    end

    assign contrib[c] = c_r[c];
  end

endmodule

@@ sv/vtf_sum.sv @@
// Registered adder tree over all slot contributions and the saturating output register.
// Depends on vtf_pkg.
module vtf_sum import vtf_pkg::*; #(
  parameter int NUM_FUNCS = NUM_FUNCS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  contrib_t                  contrib [NUM_FUNCS][3],
  output logic signed [VALUE_W-1:0] emit_red,
  output logic signed [VALUE_W-1:0] emit_green,
  output logic signed [VALUE_W-1:0] emit_blue
);

  localparam int LVL  = $clog2(NUM_FUNCS);
  localparam int NPAD = 1 << LVL;
  localparam int TL   = (LVL > 0) ? LVL : 1;

  logic signed [SUM_W-1:0]   node_r [1:TL][NPAD][3];
  logic signed [SUM_W-1:0]   total  [3];
  logic signed [VALUE_W-1:0] emit_r [3];

  for (genvar lv = 1; lv <= LVL; lv++) begin : g_lvl
    for (genvar j = 0; j < (NPAD >> lv); j++) begin : g_node
      for (genvar c = 0; c < 3; c++) begin : g_ch
        if (lv == 1) begin : g_leaf
          logic signed [SUM_W-1:0] lo, hi;
          if (2 * j < NUM_FUNCS) begin : g_lo
            assign lo = SUM_W'(contrib[2*j][c]);
          end else begin : g_lo0
            assign lo = '0;
          end
          if (2 * j + 1 < NUM_FUNCS) begin : g_hi
            assign hi = SUM_W'(contrib[2*j+1][c]);
          end else begin : g_hi0
            assign hi = '0;
          end
          always_ff @(posedge clk) begin
            if (en) begin
              node_r[lv][j][c] <= lo + hi;
            end
          end
        end else begin : g_inner
          always_ff @(posedge clk) begin
            if (en) begin
              node_r[lv][j][c] <= node_r[lv-1][2*j][c] + node_r[lv-1][2*j+1][c];
            end
          end
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_out
    if (LVL == 0) begin : g_single
      assign total[c] = SUM_W'(contrib[0][c]);
    end else begin : g_tree
      assign total[c] = node_r[TL][0][c];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        emit_r[c] <= sat32(total[c]);
      end
    end
  end

  assign emit_red   = emit_r[0];
  assign emit_green = emit_r[1];
  assign emit_blue  = emit_r[2];

endmodule

@@ sv/volume_transfer_function_eval_top.sv @@
// Volume-rendering emission transfer function, top level.
// Sample transactions: one accepted per cycle unless the output stalls or a load is busy;
// results pass through the seven-stage slot lanes, the registered adder tree and the
// saturating output register. Load transactions wait for the pipeline to drain; a gaussian
// first squares sigma and runs a 48-step divider. No input is taken meanwhile. Synchronous
// active-low reset clears the slot types, value selects, active count and all valid bits.
module volume_transfer_function_eval_top import vtf_pkg::*; #(
  parameter int NUM_FUNCS       = NUM_FUNCS_DEF,
  parameter int NUM_VALUES      = NUM_VALUES_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ACT_W-1:0]          cfg_active_count,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic [KIND_W-1:0]         in_func_type,
  input  logic [VSEL_W-1:0]         in_value_select,
  input  logic signed [VALUE_W-1:0] in_param_a,
  input  logic signed [VALUE_W-1:0] in_param_b,
  input  logic [COLOR_W-1:0]        in_color_rgb,
  input  logic signed [VALUE_W-1:0] in_value_density,
  input  logic signed [VALUE_W-1:0] in_value_thermal_energy,
  input  logic signed [VALUE_W-1:0] in_value_velocity_x,
  input  logic signed [VALUE_W-1:0] in_value_velocity_y,
  input  logic signed [VALUE_W-1:0] in_value_velocity_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_emit_red,
  output logic signed [VALUE_W-1:0] out_emit_green,
  output logic signed [VALUE_W-1:0] out_emit_blue
);

  localparam int STAGES = LANE_STAGES + $clog2(NUM_FUNCS);

  logic [ACT_W-1:0]          active_count_r;
  logic [STAGES-1:0]         vld_r, vld_nxt;
  logic                      out_valid_r;
  logic                      en;
  logic                      ld_idle;
  logic                      in_acc;
  logic                      ld_start;
  logic                      pipe_empty;
  logic signed [VALUE_W-1:0] smp [SAMPLE_FIELDS];
  entry_t                    ent [NUM_FUNCS];
  contrib_t                  contrib [NUM_FUNCS][3];

  assign cfg_ready  = 1'b1;
  assign en         = !out_valid_r || out_ready;
  assign in_ready   = en && ld_idle;
  assign in_acc     = in_valid && in_ready;
  assign ld_start   = in_acc && (in_kind == ITEM_LOAD) && (32'(in_slot) < NUM_FUNCS);
  assign pipe_empty = ~|vld_r;
  assign out_valid  = out_valid_r;

  assign smp[0] = in_value_density;
  assign smp[1] = in_value_thermal_energy;
  assign smp[2] = in_value_velocity_x;
  assign smp[3] = in_value_velocity_y;
  assign smp[4] = in_value_velocity_z;

  always_comb begin
    vld_nxt = {vld_r[STAGES-2:0], in_acc && (in_kind == ITEM_SAMPLE)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= '0;
      vld_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_count_r <= cfg_active_count;
      end
      if (en) begin
        vld_r       <= vld_nxt;
        out_valid_r <= vld_r[STAGES-1];
      end
    end
  end

  vtf_load #(
    .NUM_FUNCS  (NUM_FUNCS),
    .NUM_VALUES (NUM_VALUES)
  ) u_load (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_start   (ld_start),
    .ld_slot    (in_slot),
    .ld_type    (in_func_type),
    .ld_vsel    (in_value_select),
    .ld_a       (in_param_a),
    .ld_b       (in_param_b),
    .ld_color   (in_color_rgb),
    .pipe_empty (pipe_empty),
    .ld_idle    (ld_idle),
    .ent        (ent)
  );

  for (genvar i = 0; i < NUM_FUNCS; i++) begin : g_lane
    vtf_lane #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .active  (i < int'(active_count_r)),
      .ent     (ent[i]),
      .smp     (smp),
      .contrib (contrib[i])
    );
  end

  vtf_sum #(
    .NUM_FUNCS (NUM_FUNCS)
  ) u_sum (
    .clk        (clk),
    .en         (en),
    .contrib    (contrib),
    .emit_red   (out_emit_red),
    .emit_green (out_emit_green),
    .emit_blue  (out_emit_blue)
  );

endmodule

@@ tb/sv/tb_volume_transfer_function_eval_top.sv @@
// Self-checking testbench for volume_transfer_function_eval_top: directed and random loads
// and samples, with a transfer-table predictor and an in-order scoreboard of emissions.
// Depends on vtf_pkg and the block's top level only.
`timescale 1ns / 100ps

module tb_volume_transfer_function_eval_top import vtf_pkg::*; ();

  localparam int TABLE_SLOTS = 8;
  localparam int ROM_DEPTH   = 256;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 100;

  typedef struct {
    logic                      kind;
    logic [SLOT_W-1:0]         slot;
    logic [KIND_W-1:0]         ftype;
    logic [VSEL_W-1:0]         vsel;
    logic signed [VALUE_W-1:0] pa;
    logic signed [VALUE_W-1:0] pb;
    logic [COLOR_W-1:0]        color;
    logic signed [VALUE_W-1:0] vals [SAMPLE_FIELDS];
  } txn_t;

  typedef struct {
    logic signed [VALUE_W-1:0] red;
    logic signed [VALUE_W-1:0] green;
    logic signed [VALUE_W-1:0] blue;
  } emission_t;

  class emission_scoreboard;
    logic [KIND_W-1:0]  ftab_kind  [TABLE_SLOTS];
    logic [VSEL_W-1:0]  ftab_vsel  [TABLE_SLOTS];
    longint             ftab_low   [TABLE_SLOTS];
    longint             ftab_high  [TABLE_SLOTS];
    longint             ftab_mean  [TABLE_SLOTS];
    longint unsigned    ftab_scale [TABLE_SLOTS];
    logic [COLOR_W-1:0] ftab_color [TABLE_SLOTS];
    longint unsigned    exp_rom    [ROM_DEPTH];
    int unsigned        slots_evaluated;
    emission_t          pending_emissions [$];
    int                 mismatches;
    int                 samples_seen;
    int                 loads_seen;

    function new();
      longint unsigned e1, v, x, n, r;
      e1 = series_exp(64'd1 << 30);
      for (int k = 0; k < ROM_DEPTH; k++) begin
        x = 8 * k;
        n = x / ROM_DEPTH;
        r = x % ROM_DEPTH;
        v = series_exp((r << 30) / ROM_DEPTH);
        for (int j = 0; j < n; j++) v = (v * e1) >> 30;
        exp_rom[k] = (v + 8192) >> 14;
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        ftab_kind[i] = FT_DISABLED;
        ftab_vsel[i] = VS_DENSITY;
        ftab_low[i] = 0; ftab_high[i] = 0; ftab_mean[i] = 0;
        ftab_scale[i] = 0; ftab_color[i] = '0;
      end
      slots_evaluated = 0;
      mismatches = 0;
      samples_seen = 0;
      loads_seen = 0;
    endfunction

    function longint unsigned series_exp(longint unsigned f);
      longint unsigned term, pos, neg;
      term = 64'd1 << 30;
      pos = term;
      neg = 0;
      for (int i = 1; i <= 24; i++) begin
        term = ((term * f) >> 30) / i;
        if (i % 2 == 1) neg += term; else pos += term;
      end
      return pos - neg;
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void set_active(int unsigned n);
      slots_evaluated = n;
    endfunction

    function int pending();
      return pending_emissions.size();
    endfunction

    function void load_entry(txn_t t);
      logic [KIND_W-1:0] ft;
      longint a, b;
      longint unsigned mag, s2, q;
      ft = (t.vsel >= SAMPLE_FIELDS) ? FT_DISABLED : t.ftype;
      a = t.pa;
      b = t.pb;
      ftab_kind[t.slot]  = ft;
      ftab_vsel[t.slot]  = t.vsel;
      ftab_color[t.slot] = t.color;
      ftab_mean[t.slot]  = a;
      ftab_scale[t.slot] = 0;
      ftab_low[t.slot]   = 0;
      ftab_high[t.slot]  = 0;
      case (ft)
        FT_CONST: ftab_high[t.slot] = 64'sd2147483647;
        FT_TOPHAT: begin
          ftab_low[t.slot]  = a;
          ftab_high[t.slot] = b;
        end
        FT_GAUSS: begin
          mag = (b < 0) ? -b : b;
          s2 = mag * mag;
          ftab_low[t.slot]  = clamp32(a - 4 * b);
          ftab_high[t.slot] = clamp32(a + 4 * b);
          if (s2 == 0) begin
            q = 64'hFFFF_FFFF;
          end else begin
            q = ((64'd1 << 47) + s2 / 2) / s2;
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
          end
          ftab_scale[t.slot] = q;
        end
        default: ;
      endcase
    endfunction

    function void note_input(txn_t t);
      longint sums [3];
      longint v, d;
      longint unsigned ud, wt, chan;
      logic [127:0] prod;
      int unsigned n;
      emission_t e;
      if (t.kind == ITEM_LOAD) begin
        loads_seen++;
        load_entry(t);
        return;
      end
      samples_seen++;
      sums = '{0, 0, 0};
      n = (slots_evaluated > TABLE_SLOTS) ? TABLE_SLOTS : slots_evaluated;
      for (int i = 0; i < n; i++) begin
        if (ftab_kind[i] == FT_DISABLED) continue;
        v = (ftab_vsel[i] < SAMPLE_FIELDS) ? longint'(t.vals[ftab_vsel[i]]) : 0;
        if (v < ftab_low[i] || v > ftab_high[i]) continue;
        if (ftab_kind[i] == FT_GAUSS) begin
          d = v - ftab_mean[i];
          ud = (d < 0) ? -d : d;
          prod = 128'(ud * ud) * 128'(ftab_scale[i]);
          wt = (prod >= (128'd1 << 51)) ? exp_rom[ROM_DEPTH-1] : exp_rom[prod >> 43];
          for (int c = 0; c < 3; c++) begin
            chan = ftab_color[i] >> (32 - 16 * c) & 64'hFFFF;
            sums[c] += longint'((chan * wt) >> 8);
          end
        end else begin
          for (int c = 0; c < 3; c++) begin
            chan = ftab_color[i] >> (32 - 16 * c) & 64'hFFFF;
            sums[c] += (longint'(chan) * v) >>> 8;
          end
        end
      end
      e.red   = VALUE_W'(clamp32(sums[0]));
      e.green = VALUE_W'(clamp32(sums[1]));
      e.blue  = VALUE_W'(clamp32(sums[2]));
      pending_emissions.insert(pending_emissions.size(), e);
    endfunction

    function void check_result(emission_t got);
      emission_t want;
      if (pending_emissions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction: %0d %0d %0d", got.red, got.green, got.blue);
        return;
      end
      want = pending_emissions.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ACT_W-1:0] cfg_active_count = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [KIND_W-1:0] in_func_type = '0;
  logic [VSEL_W-1:0] in_value_select = '0;
  logic signed [VALUE_W-1:0] in_param_a = '0;
  logic signed [VALUE_W-1:0] in_param_b = '0;
  logic [COLOR_W-1:0] in_color_rgb = '0;
  logic signed [VALUE_W-1:0] in_value_density = '0;
  logic signed [VALUE_W-1:0] in_value_thermal_energy = '0;
  logic signed [VALUE_W-1:0] in_value_velocity_x = '0;
  logic signed [VALUE_W-1:0] in_value_velocity_y = '0;
  logic signed [VALUE_W-1:0] in_value_velocity_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_emit_red;
  logic signed [VALUE_W-1:0] out_emit_green;
  logic signed [VALUE_W-1:0] out_emit_blue;

  emission_scoreboard sb = new();
  bit idle_enable = 1'b1;
  bit hold_request = 1'b0;
  int cycle_count = 0;
  int results_seen = 0;
  logic signed [VALUE_W-1:0] centre_pool [TABLE_SLOTS];

  volume_transfer_function_eval_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_active_count(cfg_active_count),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_slot(in_slot),
    .in_func_type(in_func_type), .in_value_select(in_value_select),
    .in_param_a(in_param_a), .in_param_b(in_param_b), .in_color_rgb(in_color_rgb),
    .in_value_density(in_value_density), .in_value_thermal_energy(in_value_thermal_energy),
    .in_value_velocity_x(in_value_velocity_x), .in_value_velocity_y(in_value_velocity_y),
    .in_value_velocity_z(in_value_velocity_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_emit_red(out_emit_red), .out_emit_green(out_emit_green), .out_emit_blue(out_emit_blue)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    emission_t got;
    if (rst_n && out_valid && out_ready) begin
      got.red = out_emit_red;
      got.green = out_emit_green;
      got.blue = out_emit_blue;
      sb.check_result(got);
      results_seen++;
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_txn(txn_t t);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_kind <= t.kind;
    in_slot <= t.slot;
    in_func_type <= t.ftype;
    in_value_select <= t.vsel;
    in_param_a <= t.pa;
    in_param_b <= t.pb;
    in_color_rgb <= t.color;
    in_value_density <= t.vals[0];
    in_value_thermal_energy <= t.vals[1];
    in_value_velocity_x <= t.vals[2];
    in_value_velocity_y <= t.vals[3];
    in_value_velocity_z <= t.vals[4];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(t);
    if (t.kind == ITEM_LOAD) centre_pool[t.slot] = t.pa;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_active(logic [ACT_W-1:0] n);
    cfg_active_count <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_active(n);
  endtask

  function automatic txn_t random_fill();
    txn_t t;
    t.kind = 1'($urandom_range(0, 1));
    t.slot = SLOT_W'($urandom);
    t.ftype = KIND_W'($urandom);
    t.vsel = VSEL_W'($urandom);
    t.pa = $urandom;
    t.pb = $urandom;
    t.color = COLOR_W'({$urandom, $urandom});
    foreach (t.vals[i]) t.vals[i] = $urandom;
    return t;
  endfunction

  function automatic txn_t load_txn(int s, logic [KIND_W-1:0] ft, int vs,
                                    logic signed [31:0] a, logic signed [31:0] b,
                                    logic [47:0] col);
    txn_t t;
    t = random_fill();
    t.kind = ITEM_LOAD; t.slot = SLOT_W'(s); t.ftype = ft; t.vsel = VSEL_W'(vs);
    t.pa = a; t.pb = b; t.color = col;
    return t;
  endfunction

  function automatic txn_t sample_txn(logic signed [31:0] v);
    txn_t t;
    t = random_fill();
    t.kind = ITEM_SAMPLE;
    foreach (t.vals[i]) t.vals[i] = v;
    return t;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
      2: return centre_pool[$urandom_range(0, 7)] + $signed($urandom_range(0, 8 << 16))
                - (4 << 16);
      3: return centre_pool[$urandom_range(0, 7)];
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  function automatic txn_t random_txn();
    txn_t t;
    t = random_fill();
    if ($urandom_range(0, 4) == 0) begin
      t.kind = ITEM_LOAD;
      if ($urandom_range(0, 7) != 0) t.vsel = VSEL_W'($urandom_range(0, 4));
      if ($urandom_range(0, 2) != 0) t.pa = $signed($urandom_range(0, 16 << 16)) - (8 << 16);
      case ($urandom_range(0, 3))
        0: t.pb = $urandom_range(1, 8 << 16);
        1: t.pb = t.pa + $signed($urandom_range(0, 8 << 16));
        2: t.pb = $urandom_range(1, 1 << 12);
        default: ;
      endcase
    end else begin
      t.kind = ITEM_SAMPLE;
      foreach (t.vals[i]) if ($urandom_range(0, 3) != 0) t.vals[i] = pick_value();
    end
    return t;
  endfunction

  initial begin
    logic [ACT_W-1:0] phase_counts [6];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every function type and every window corner case.
    write_active(4'd8);
    send_txn(sample_txn(32'sd65536));
    send_txn(load_txn(0, FT_CONST, VS_DENSITY, 0, 0, 48'hFFFF_FFFF_FFFF));
    send_txn(load_txn(1, FT_TOPHAT, VS_THERMAL, -(100 << 16), 100 << 16, 48'h0100_0200_8000));
    send_txn(load_txn(2, FT_GAUSS, VS_VEL_X, 0, 1 << 16, 48'hFFFF_0001_1234));
    send_txn(load_txn(3, FT_GAUSS, VS_VEL_Y, 5 << 16, 0, 48'h0100_0100_0100));
    send_txn(load_txn(4, FT_GAUSS, VS_VEL_Z, 0, -(1 << 16), 48'hFFFF_FFFF_FFFF));
    send_txn(load_txn(5, FT_TOPHAT, VS_DENSITY, 10 << 16, -(10 << 16), 48'hFFFF_FFFF_FFFF));
    send_txn(load_txn(6, FT_CONST, 5, 0, 0, 48'hFFFF_FFFF_FFFF));
    send_txn(load_txn(7, FT_GAUSS, VS_THERMAL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 48'h8000_4000_2000));
    send_txn(sample_txn(0));
    send_txn(sample_txn(32'sh7FFF_FFFF));
    send_txn(sample_txn(32'sh8000_0000));
    send_txn(sample_txn(5 << 16));
    send_txn(sample_txn(-(100 << 16)));
    send_txn(sample_txn(100 << 16));
    send_txn(sample_txn(4 << 16));
    send_txn(sample_txn(-1));
    send_txn(load_txn(6, FT_TOPHAT, 7, 0, 0, 48'hFFFF_FFFF_FFFF));
    send_txn(load_txn(5, FT_DISABLED, VS_DENSITY, 0, 0, 48'hFFFF_FFFF_FFFF));
    send_txn(sample_txn(3 << 16));
    drain_and_settle();
    write_active(4'd15);
    send_txn(sample_txn(1 << 15));
    drain_and_settle();
    write_active(4'd0);
    send_txn(sample_txn(7 << 16));
    drain_and_settle();

    // Random part: several active counts, one long receiver hold, quiet final phase.
    phase_counts = '{4'd8, 4'd1, 4'd15, 4'($urandom_range(0, 15)), 4'd0, 4'd8};
    for (int p = 0; p < 6; p++) begin
      write_active(phase_counts[p]);
      if (p == 5) idle_enable = 1'b0;
      for (int i = 0; i < 100; i++) begin
        if (p == 2 && i == 20) hold_request = 1'b1;
        send_txn(random_txn());
      end
      drain_and_settle();
    end

    $display("Run covered %0d loads and %0d samples, %0d emissions checked, %0d mismatches.",
             sb.loads_seen, sb.samples_seen, results_seen, sb.mismatches);
    $display("Active counts swept from zero to fifteen, with stalls on both channels.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/vtf_pkg.sv
sv/vtf_load.sv
sv/vtf_lane.sv
sv/vtf_sum.sv
sv/volume_transfer_function_eval_top.sv
tb/sv/tb_volume_transfer_function_eval_top.sv
